// ----- rtl/core/zup_pkg.sv -----
// Shared types, widths and constants for the z to u-parameter converter.
// No dependencies; every other file of the block imports this package.
package zup_pkg;

  localparam int XW  = 32;
  localparam int PW  = 64;
  localparam int CW  = 66;
  localparam int NW  = 68;
  localparam int PLW = XW + 33;
  localparam int PRW = 101;
  localparam int DW  = 97;
  localparam int QB  = 33;
  localparam int ROOT_W = 32;

  localparam int FR_ST  = 5;
  localparam int DIV_ST = QB + 2;
  localparam int NST    = FR_ST + DIV_ST + 1;

  typedef logic signed [XW-1:0]  fix_t;
  typedef logic signed [PRW-1:0] pr_t;

  typedef struct packed {
    fix_t z11_re;
    fix_t z11_im;
    fix_t z12_re;
    fix_t z12_im;
    fix_t z21_re;
    fix_t z21_im;
    fix_t z22_re;
    fix_t z22_im;
  } zmat_t;

  typedef struct packed {
    fix_t ref1_re;
    fix_t ref1_im;
    fix_t ref2_re;
    fix_t ref2_im;
  } ref_t;

  typedef struct packed {
    ref_t              refs;
    logic [ROOT_W-1:0] root;
    logic              busy;
  } cfg_stat_t;

  typedef enum logic [1:0] {
    REG_REF1_RE = 2'd0,
    REG_REF1_IM = 2'd1,
    REG_REF2_RE = 2'd2,
    REG_REF2_IM = 2'd3
  } reg_idx_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [1:0] ERR_SAT      = 2'd2;

  localparam fix_t REF_RE_RST = 32'sd3276800;
  localparam fix_t SAT_POS    = 32'sh7FFF_FFFF;
  localparam fix_t SAT_NEG    = 32'sh8000_0000;

  function automatic logic signed [PW-1:0] smul(fix_t x, fix_t y);
    smul = PW'(x) * PW'(y);
  endfunction

endpackage

// ----- rtl/core/zup_cfg.sv -----
// Reference impedance registers and the iterative square root of |Re z1|*|Re z2|.
// Depends on zup_pkg.
module zup_cfg import zup_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_stat_t   stat
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_FIN  = 4'b1000
  } st_t;

  st_t               st_r, st_nxt;
  ref_t              refs_r;
  logic [63:0]       p_r, p_nxt, res_r, res_nxt, bitv, sum;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [31:0]       a1, a2;
  logic              wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  assign a1   = refs_r.ref1_re[31] ? 32'(-refs_r.ref1_re) : 32'(refs_r.ref1_re);
  assign a2   = refs_r.ref2_re[31] ? 32'(-refs_r.ref2_re) : 32'(refs_r.ref2_re);
  assign bitv = 64'd1 << (6'd62 - {cnt_r, 1'b0});
  assign sum  = res_r + bitv;

  always_comb begin
    st_nxt   = st_r;
    p_nxt    = p_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    root_nxt = root_r;
    unique case (st_r)
      ST_IDLE: ;
      ST_MUL: begin
        p_nxt   = 64'(a1) * 64'(a2);
        res_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (p_r >= sum) begin
          p_nxt   = p_r - sum;
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        root_nxt = res_r[ROOT_W-1:0] + ROOT_W'(p_r > res_r);
        st_nxt   = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (wr) st_nxt = ST_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_MUL;
      cnt_r          <= '0;
      refs_r.ref1_re <= REF_RE_RST;
      refs_r.ref1_im <= '0;
      refs_r.ref2_re <= REF_RE_RST;
      refs_r.ref2_im <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (wr) begin
        unique case (reg_idx_t'(cfg_index))
          REG_REF1_RE: refs_r.ref1_re <= cfg_wdata;
          REG_REF1_IM: refs_r.ref1_im <= cfg_wdata;
          REG_REF2_RE: refs_r.ref2_re <= cfg_wdata;
          REG_REF2_IM: refs_r.ref2_im <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    res_r  <= res_nxt;
    root_r <= root_nxt;
  end

  assign stat.refs = refs_r;
  assign stat.root = root_r;
  assign stat.busy = (st_r != ST_IDLE);

endmodule

// ----- rtl/core/zup_front.sv -----
// Multiply and accumulate front end: numerators, their products with conj(z12)
// and the divisor magnitude, five register stages. Depends on zup_pkg.
module zup_front import zup_pkg::*; (
  input  logic              clk,
  input  logic [FR_ST-1:0]  en,
  input  zmat_t             z,
  input  ref_t              rf,
  input  logic [ROOT_W-1:0] root,
  output pr_t               pr [8],
  output logic [DW-1:0]     dmag
);

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cp_t;
  typedef logic signed [NW-1:0] num_t;

  prod_t m_ar2_r, m_bi2_r, m_ai2_r, m_br2_r;
  prod_t m_cr1_r, m_di1_r, m_ci1_r, m_dr1_r;
  prod_t m_r1r2_r, m_i1i2_r, m_r1i2_r, m_i1r2_r;
  prod_t m_ac_r, m_bd_r, m_ad_r, m_bc_r;
  prod_t m_eg_r, m_fh_r, m_eh_r, m_fg_r;
  prod_t m_ee_r, m_ff_r;
  fix_t  e_r [3];
  fix_t  f_r [3];

  cp_t a_re_r, a_im_r, ac_re_r, ac_im_r, b_re_r, b_im_r, bc_re_r, bc_im_r;
  cp_t c_re_r, c_im_r, cc_re_r, cc_im_r, dt_re_r, dt_im_r;
  logic [PW-1:0] mag2_r [2];

  num_t n_r [8];

  logic signed [NW-1:0]  ph_r [8][2];
  logic signed [PLW-1:0] pl_r [8][2];
  logic [PLW-1:0]        dh_r, dl_r;
  logic [ROOT_W:0]       s2;

  function automatic pr_t pjoin(logic signed [NW-1:0] h, logic signed [PLW-1:0] l);
    pjoin = (PRW'(h) <<< XW) + PRW'(l);
  endfunction

  assign s2 = {root, 1'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_ar2_r  <= smul(z.z11_re, rf.ref2_re);
      m_bi2_r  <= smul(z.z11_im, rf.ref2_im);
      m_ai2_r  <= smul(z.z11_re, rf.ref2_im);
      m_br2_r  <= smul(z.z11_im, rf.ref2_re);
      m_cr1_r  <= smul(z.z22_re, rf.ref1_re);
      m_di1_r  <= smul(z.z22_im, rf.ref1_im);
      m_ci1_r  <= smul(z.z22_re, rf.ref1_im);
      m_dr1_r  <= smul(z.z22_im, rf.ref1_re);
      m_r1r2_r <= smul(rf.ref1_re, rf.ref2_re);
      m_i1i2_r <= smul(rf.ref1_im, rf.ref2_im);
      m_r1i2_r <= smul(rf.ref1_re, rf.ref2_im);
      m_i1r2_r <= smul(rf.ref1_im, rf.ref2_re);
      m_ac_r   <= smul(z.z11_re, z.z22_re);
      m_bd_r   <= smul(z.z11_im, z.z22_im);
      m_ad_r   <= smul(z.z11_re, z.z22_im);
      m_bc_r   <= smul(z.z11_im, z.z22_re);
      m_eg_r   <= smul(z.z12_re, z.z21_re);
      m_fh_r   <= smul(z.z12_im, z.z21_im);
      m_eh_r   <= smul(z.z12_re, z.z21_im);
      m_fg_r   <= smul(z.z12_im, z.z21_re);
      m_ee_r   <= smul(z.z12_re, z.z12_re);
      m_ff_r   <= smul(z.z12_im, z.z12_im);
      e_r[0]   <= z.z12_re;
      f_r[0]   <= z.z12_im;
    end
    if (en[1]) begin
      a_re_r    <= CW'(m_ar2_r) - CW'(m_bi2_r);
      a_im_r    <= CW'(m_ai2_r) + CW'(m_br2_r);
      ac_re_r   <= CW'(m_ar2_r) + CW'(m_bi2_r);
      ac_im_r   <= CW'(m_br2_r) - CW'(m_ai2_r);
      b_re_r    <= CW'(m_cr1_r) - CW'(m_di1_r);
      b_im_r    <= CW'(m_ci1_r) + CW'(m_dr1_r);
      bc_re_r   <= CW'(m_cr1_r) + CW'(m_di1_r);
      bc_im_r   <= CW'(m_dr1_r) - CW'(m_ci1_r);
      c_re_r    <= CW'(m_r1r2_r) - CW'(m_i1i2_r);
      c_im_r    <= CW'(m_r1i2_r) + CW'(m_i1r2_r);
      cc_re_r   <= CW'(m_r1r2_r) + CW'(m_i1i2_r);
      cc_im_r   <= CW'(m_r1i2_r) - CW'(m_i1r2_r);
      dt_re_r   <= CW'(m_ac_r) - CW'(m_bd_r) - CW'(m_eg_r) + CW'(m_fh_r);
      dt_im_r   <= CW'(m_ad_r) + CW'(m_bc_r) - CW'(m_eh_r) - CW'(m_fg_r);
      mag2_r[0] <= PW'(m_ee_r + m_ff_r);
      e_r[1]    <= e_r[0];
      f_r[1]    <= f_r[0];
    end
    if (en[2]) begin
      n_r[0]    <= NW'(a_re_r) + NW'(dt_re_r) + NW'(b_re_r) + NW'(c_re_r);
      n_r[1]    <= NW'(a_im_r) + NW'(dt_im_r) + NW'(b_im_r) + NW'(c_im_r);
      n_r[2]    <= NW'(bc_re_r) + NW'(cc_re_r) - NW'(a_re_r) - NW'(dt_re_r);
      n_r[3]    <= NW'(bc_im_r) + NW'(cc_im_r) - NW'(a_im_r) - NW'(dt_im_r);
      n_r[4]    <= NW'(dt_re_r) + NW'(b_re_r) - NW'(ac_re_r) - NW'(cc_re_r);
      n_r[5]    <= NW'(dt_im_r) + NW'(b_im_r) - NW'(ac_im_r) + NW'(cc_im_r);
      n_r[6]    <= NW'(ac_re_r) + NW'(bc_re_r) - NW'(dt_re_r) - NW'(c_re_r);
      n_r[7]    <= NW'(ac_im_r) + NW'(bc_im_r) - NW'(dt_im_r) + NW'(c_im_r);
      mag2_r[1] <= mag2_r[0];
      e_r[2]    <= e_r[1];
      f_r[2]    <= f_r[1];
    end
    if (en[3]) begin
      for (int k = 0; k < 8; k++) begin
        ph_r[k][0] <= NW'($signed(n_r[k][NW-1:XW])) * NW'(e_r[2]);
        ph_r[k][1] <= NW'($signed(n_r[k][NW-1:XW])) * NW'(f_r[2]);
        pl_r[k][0] <= PLW'($signed({1'b0, n_r[k][XW-1:0]})) * PLW'(e_r[2]);
        pl_r[k][1] <= PLW'($signed({1'b0, n_r[k][XW-1:0]})) * PLW'(f_r[2]);
      end
      dh_r <= PLW'(s2) * PLW'(mag2_r[1][PW-1:XW]);
      dl_r <= PLW'(s2) * PLW'(mag2_r[1][XW-1:0]);
    end
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        pr[2*k]   <= pjoin(ph_r[2*k][0], pl_r[2*k][0])
                   + pjoin(ph_r[2*k+1][1], pl_r[2*k+1][1]);
        pr[2*k+1] <= pjoin(ph_r[2*k+1][0], pl_r[2*k+1][0])
                   - pjoin(ph_r[2*k][1], pl_r[2*k][1]);
      end
      dmag <= (DW'(dh_r) << XW) + DW'(dl_r);
    end
  end

endmodule

// ----- rtl/core/zup_div.sv -----
// Eight-lane pipelined restoring divider: one quotient bit per stage, then
// round half away from zero and saturate. Depends on zup_pkg.
module zup_div import zup_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic [DIV_ST-1:0] en,
  input  pr_t               pr [8],
  input  logic [DW-1:0]     dmag,
  input  logic              dneg,
  output fix_t              val [8],
  output logic [7:0]        sat
);

  localparam int NUMW = PRW - 1 + FRAC_BITS;
  localparam int RW   = (NUMW > DW + QB) ? NUMW : DW + QB;
  localparam logic [QB:0] LIM_POS = (QB+1)'(32'h7FFF_FFFF);
  localparam logic [QB:0] LIM_NEG = (QB+1)'(32'h8000_0000);

  typedef logic [RW-1:0] rem_t;

  logic [DW-1:0] d_r   [QB+1];
  rem_t          rem_r [8][QB+1];
  logic [QB-1:0] q_r   [8][QB+1];
  logic          ovf_r [8][QB+1];
  logic          neg_r [8][QB+1];

  function automatic rem_t mag_sh(pr_t x);
    logic [PRW-1:0] m;
    m = x[PRW-1] ? PRW'(-x) : PRW'(x);
    mag_sh = rem_t'(m) << FRAC_BITS;
  endfunction

  function automatic logic [XW:0] fin(rem_t rem, logic [QB-1:0] q, logic [DW-1:0] d,
                                       logic ovf, logic neg);
    logic [QB:0] qq;
    logic        s;
    qq = {1'b0, q} + (QB+1)'((rem << 1) >= rem_t'(d));
    s  = ovf | (qq > (neg ? LIM_NEG : LIM_POS));
    if (s) fin = {1'b1, neg ? SAT_NEG : SAT_POS};
    else   fin = {1'b0, neg ? XW'(-qq[XW-1:0]) : qq[XW-1:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r[0] <= dmag;
      for (int l = 0; l < 8; l++) begin
        rem_r[l][0] <= mag_sh(pr[l]);
        q_r[l][0]   <= '0;
        ovf_r[l][0] <= mag_sh(pr[l]) >= (rem_t'(dmag) << QB);
        neg_r[l][0] <= pr[l][PRW-1] ^ dneg;
      end
    end
    for (int j = 1; j <= QB; j++) begin
      if (en[j]) begin
        d_r[j] <= d_r[j-1];
        for (int l = 0; l < 8; l++) begin
          if (rem_r[l][j-1] >= (rem_t'(d_r[j-1]) << (QB - j))) begin
            rem_r[l][j] <= rem_r[l][j-1] - (rem_t'(d_r[j-1]) << (QB - j));
            q_r[l][j]   <= q_r[l][j-1] | (QB'(1) << (QB - j));
          end else begin
            rem_r[l][j] <= rem_r[l][j-1];
            q_r[l][j]   <= q_r[l][j-1];
          end
          ovf_r[l][j] <= ovf_r[l][j-1];
          neg_r[l][j] <= neg_r[l][j-1];
        end
      end
    end
    if (en[QB+1]) begin
      for (int l = 0; l < 8; l++) begin
        {sat[l], val[l]} <= fin(rem_r[l][QB], q_r[l][QB], d_r[QB], ovf_r[l][QB],
                                neg_r[l][QB]);
      end
    end
  end

endmodule

// ----- rtl/core/two_port_z_to_u_parameter_convert.sv -----
// Top level of the two-port z to u-parameter converter.
// Depends on zup_pkg, zup_cfg, zup_front and zup_div.
//
// Usage:
//   Input channel in_*: one beat carries a complex 2x2 impedance matrix.
//   Output channel out_*: one beat carries the four complex u-parameters and
//   error_code (0 ok, 1 zero divisor with all parts zero, 2 saturated).
//   Config channel cfg_*: writes ref1_re, ref1_im, ref2_re, ref2_im by index;
//   cfg_ready is always high. Write only while no beat is in flight.
// Pipeline:
//   A beat passes five multiply and add stages, 35 divider stages (one
//   quotient bit per stage between load and rounding, 8 lanes in parallel)
//   and the output register. Throughput is one beat per cycle unless stalled or busy.
// Reset and config:
//   Reset loads 50 ohm real references. After reset and after every config
//   write the scale sqrt(|Re z1|*|Re z2|) is recomputed by an iterative unit,
//   one root bit per cycle; in_ready stays low meanwhile.
// Stall:
//   Every stage holds its beat while the next one is full and stalled; empty
//   stages still fill, so inputs are taken until the pipeline is full.
module two_port_z_to_u_parameter_convert import zup_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  fix_t        in_z11_re,
  input  fix_t        in_z11_im,
  input  fix_t        in_z12_re,
  input  fix_t        in_z12_im,
  input  fix_t        in_z21_re,
  input  fix_t        in_z21_im,
  input  fix_t        in_z22_re,
  input  fix_t        in_z22_im,
  output logic        out_valid,
  input  logic        out_ready,
  output fix_t        out_u11_re,
  output fix_t        out_u11_im,
  output fix_t        out_u12_re,
  output fix_t        out_u12_im,
  output fix_t        out_u21_re,
  output fix_t        out_u21_im,
  output fix_t        out_u22_re,
  output fix_t        out_u22_im,
  output logic [1:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_stat_t         cs;
  zmat_t             zin;
  logic [NST-1:0]    v_r, en;
  logic [NST-2:0]    err_r;
  logic              in_fire, err_in;
  pr_t               pr [8];
  logic [DW-1:0]     dmag;
  fix_t              val [8];
  logic [7:0]        sat;
  fix_t              u_r [8];
  logic [1:0]        ec_r;

  zup_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (cs)
  );

  assign zin = '{in_z11_re, in_z11_im, in_z12_re, in_z12_im,
                 in_z21_re, in_z21_im, in_z22_re, in_z22_im};

  assign en[NST-1] = !v_r[NST-1] | out_ready;
  for (genvar i = 0; i < NST - 1; i++) begin : g_en
    assign en[i] = !v_r[i] | en[i+1];
  end

  assign in_ready = en[0] & !cs.busy;
  assign in_fire  = in_valid & in_ready;
  assign err_in   = (in_z12_re == '0 && in_z12_im == '0) ||
                    cs.refs.ref1_re == '0 || cs.refs.ref2_re == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_fire;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) err_r[0] <= err_in;
    for (int i = 1; i < NST - 1; i++) begin
      if (en[i]) err_r[i] <= err_r[i-1];
    end
  end

  zup_front u_front (
    .clk  (clk),
    .en   (en[FR_ST-1:0]),
    .z    (zin),
    .rf   (cs.refs),
    .root (cs.root),
    .pr   (pr),
    .dmag (dmag)
  );

  zup_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .en   (en[NST-2:FR_ST]),
    .pr   (pr),
    .dmag (dmag),
    .dneg (cs.refs.ref1_re[XW-1]),
    .val  (val),
    .sat  (sat)
  );

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      for (int l = 0; l < 8; l++) begin
        u_r[l] <= err_r[NST-2] ? '0 : val[l];
      end
      if (err_r[NST-2]) ec_r <= ERR_ZERO_DIV;
      else              ec_r <= (|sat) ? ERR_SAT : ERR_NONE;
    end
  end

  assign out_valid      = v_r[NST-1];
  assign out_u11_re     = u_r[0];
  assign out_u11_im     = u_r[1];
  assign out_u12_re     = u_r[2];
  assign out_u12_im     = u_r[3];
  assign out_u21_re     = u_r[4];
  assign out_u21_im     = u_r[5];
  assign out_u22_re     = u_r[6];
  assign out_u22_im     = u_r[7];
  assign out_error_code = ec_r;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cs.busy |-> !in_ready)
    else $error("input accepted while scale unit busy");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted beat missing from first stage");

  a_zero_div_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_ZERO_DIV |->
      out_u11_re == '0 && out_u11_im == '0 && out_u12_re == '0 && out_u12_im == '0 &&
      out_u21_re == '0 && out_u21_im == '0 && out_u22_re == '0 && out_u22_im == '0)
    else $error("zero divisor beat carries nonzero parameters");

endmodule
